// File: rtl/core/assert_macros.svh
// Assertion macros shared by the life grid RTL.
// Define ASSERT_OFF to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property checked at every rising edge outside reset.
`define LGS_ASSERT(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
	else $error("life grid assertion failed");

// Condition that must never be true outside reset.
`define LGS_ASSERT_NEVER(lbl, ck, rn, cond) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (!(cond))) \
	else $error("life grid forbidden condition seen");

`else

`define LGS_ASSERT(lbl, ck, rn, prop)
`define LGS_ASSERT_NEVER(lbl, ck, rn, cond)

`endif

`endif

// File: rtl/core/lgs_pkg.sv
// Shared types and constants of the life grid block.
// No dependencies.
`timescale 1ns / 1ps

package lgs_pkg;

	localparam int OP_W  = 2;
	localparam int IDX_W = 12;

	localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
	localparam logic [OP_W-1:0] OP_ADVANCE = 2'd1;
	localparam logic [OP_W-1:0] OP_READ    = 2'd2;

	localparam logic [3:0] SURVIVE_COUNT = 4'd2;
	localparam logic [3:0] BIRTH_COUNT   = 4'd3;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV1,
		ST_DIV2,
		ST_RD,
		ST_RMW,
		ST_ADV,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;   // request accepted: latch fields
		logic div1;   // row estimate from index
		logic div2;   // column and range check
		logic rd;     // read the addressed row
		logic rmw;    // update row / capture read bit
		logic adv;    // one step of the generation sweep
		logic clear;  // one step of the reset clearing pass
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clear_last;
		logic adv_last;
	} sts_t;

endpackage

// File: rtl/core/lgs_ram.sv
// Generic simple dual port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module lgs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/lgs_ctrl.sv
// Sequencer of the life grid block: request accept, cell access, sweep.
// Depends on lgs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lgs_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [lgs_pkg::OP_W-1:0]  op,
	input  lgs_pkg::sts_t             sts,
	output lgs_pkg::cmd_t             cmd,
	output logic                      busy,
	output logic                      done
);

	lgs_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lgs_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			lgs_pkg::ST_CLEAR: begin
				if (sts.clear_last) begin
					state_d = lgs_pkg::ST_IDLE;
				end
			end
			lgs_pkg::ST_IDLE: begin
				if (start) begin
					if (op == lgs_pkg::OP_ADVANCE) begin
						state_d = lgs_pkg::ST_ADV;
					end else if (op == lgs_pkg::OP_WRITE || op == lgs_pkg::OP_READ) begin
						state_d = lgs_pkg::ST_DIV1;
					end else begin
						state_d = lgs_pkg::ST_DONE;
					end
				end
			end
			lgs_pkg::ST_DIV1: state_d = lgs_pkg::ST_DIV2;
			lgs_pkg::ST_DIV2: state_d = lgs_pkg::ST_RD;
			lgs_pkg::ST_RD:   state_d = lgs_pkg::ST_RMW;
			lgs_pkg::ST_RMW:  state_d = lgs_pkg::ST_DONE;
			lgs_pkg::ST_ADV: begin
				if (sts.adv_last) begin
					state_d = lgs_pkg::ST_DONE;
				end
			end
			lgs_pkg::ST_DONE: state_d = lgs_pkg::ST_IDLE;
			default:          state_d = lgs_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			lgs_pkg::ST_CLEAR: cmd.clear = 1'b1;
			lgs_pkg::ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			lgs_pkg::ST_DIV1: cmd.div1 = 1'b1;
			lgs_pkg::ST_DIV2: cmd.div2 = 1'b1;
			lgs_pkg::ST_RD:   cmd.rd   = 1'b1;
			lgs_pkg::ST_RMW:  cmd.rmw  = 1'b1;
			lgs_pkg::ST_ADV:  cmd.adv  = 1'b1;
			lgs_pkg::ST_DONE: done     = 1'b1;
			default:          busy     = 1'b1;
		endcase
	end

	`LGS_ASSERT(a_done_to_idle, clk, arst_n,
		state_q == lgs_pkg::ST_DONE |=> state_q == lgs_pkg::ST_IDLE)
	`LGS_ASSERT(a_adv_entry, clk, arst_n,
		(cmd.load && op == lgs_pkg::OP_ADVANCE) |=> state_q == lgs_pkg::ST_ADV)
	`LGS_ASSERT(a_adv_holds, clk, arst_n,
		(state_q == lgs_pkg::ST_ADV && !sts.adv_last) |=> state_q == lgs_pkg::ST_ADV)

endmodule

// File: rtl/core/lgs_datapath.sv
// Datapath of the life grid block: row RAM, index split, neighbor rule.
// Depends on lgs_pkg, lgs_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lgs_datapath #(
	parameter int GRID_WIDTH  = 64,
	parameter int GRID_HEIGHT = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lgs_pkg::cmd_t             cmd,
	output lgs_pkg::sts_t             sts,
	input  logic [lgs_pkg::OP_W-1:0]  op,
	input  logic [lgs_pkg::IDX_W-1:0] cell_index,
	input  logic                      cell_value,
	output logic                      alive,
	output logic [lgs_pkg::OP_W-1:0]  done_kind
);

	localparam int IW         = lgs_pkg::IDX_W;
	localparam int CW         = $clog2(GRID_WIDTH);
	localparam int RW         = $clog2(GRID_HEIGHT);
	localparam int SW         = $clog2(GRID_HEIGHT + 2);
	localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;
	// floor(idx / W) = (idx * RECIP) >> DIV_SHIFT, exact for every IW-bit idx
	localparam int DIV_SHIFT  = IW + CW;
	localparam int RECIP      = ((1 << DIV_SHIFT) + GRID_WIDTH - 1) / GRID_WIDTH;
	localparam int MW         = IW + 2;
	localparam int PW         = DIV_SHIFT + IW;

	localparam logic [MW-1:0] RECIP_C      = MW'(RECIP);
	localparam logic [IW-1:0] WIDTH_C      = IW'(GRID_WIDTH);
	localparam logic [SW-1:0] CLEAR_LAST_C = SW'(GRID_HEIGHT - 1);
	localparam logic [SW-1:0] ADV_LAST_C   = SW'(GRID_HEIGHT + 1);
	localparam logic [SW-1:0] HEIGHT_C     = SW'(GRID_HEIGHT);
	localparam logic [SW-1:0] TWO_C        = SW'(2);

	logic [lgs_pkg::OP_W-1:0] op_q;
	logic [IW-1:0]            idx_q;
	logic                     val_q;
	logic                     alive_q;
	logic [SW-1:0]            step_q;
	logic [IW-1:0]            quot_q;
	logic [RW-1:0]            row_q;
	logic [CW-1:0]            col_q;
	logic                     in_range_q;
	logic [GRID_WIDTH-1:0]    prev_q;
	logic [GRID_WIDTH-1:0]    cur_q;

	logic                     ram_we;
	logic [RW-1:0]            ram_waddr;
	logic [GRID_WIDTH-1:0]    ram_wdata;
	logic                     ram_re;
	logic [RW-1:0]            ram_raddr;
	logic [GRID_WIDTH-1:0]    ram_rdata;

	logic [PW-1:0]            quot_prod;
	logic [IW-1:0]            row_base;
	logic [IW-1:0]            col_full;
	logic [SW-1:0]            wr_step;
	logic [GRID_WIDTH-1:0]    next_row;
	logic [GRID_WIDTH-1:0]    new_row;
	logic [GRID_WIDTH-1:0]    patched_row;

	assign quot_prod = PW'(idx_q) * PW'(RECIP_C);
	assign row_base  = quot_q * WIDTH_C;
	assign col_full  = idx_q - row_base;
	assign wr_step   = step_q - TWO_C;
	// below the last row the grid is dead
	assign next_row  = (step_q <= HEIGHT_C) ? ram_rdata : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			op_q    <= '0;
			alive_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				step_q  <= '0;
				op_q    <= op;
				alive_q <= 1'b0;
			end else if (cmd.clear || cmd.adv) begin
				step_q <= step_q + SW'(1);
			end
			if (cmd.rmw) begin
				alive_q <= (op_q == lgs_pkg::OP_READ) && in_range_q && ram_rdata[col_q];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q  <= cell_index;
			val_q  <= cell_value;
			prev_q <= '0;
			cur_q  <= '0;
		end
		if (cmd.div1) begin
			quot_q <= quot_prod[DIV_SHIFT +: IW];
		end
		if (cmd.div2) begin
			row_q      <= quot_q[RW-1:0];
			col_q      <= col_full[CW-1:0];
			in_range_q <= (32'(idx_q) < CELL_COUNT);
		end
		if (cmd.adv && step_q != '0) begin
			prev_q <= cur_q;
			cur_q  <= next_row;
		end
	end

	// B3/S23 on the middle row, columns evaluated side by side
	always_comb begin
		logic [GRID_WIDTH+1:0] pp;
		logic [GRID_WIDTH+1:0] cp;
		logic [GRID_WIDTH+1:0] np;
		logic [3:0]            nsum;
		pp = {1'b0, prev_q, 1'b0};
		cp = {1'b0, cur_q, 1'b0};
		np = {1'b0, next_row, 1'b0};
		new_row = '0;
		for (int c = 0; c < GRID_WIDTH; c++) begin
			nsum = 4'(pp[c]) + 4'(pp[c+1]) + 4'(pp[c+2])
				+ 4'(cp[c]) + 4'(cp[c+2])
				+ 4'(np[c]) + 4'(np[c+1]) + 4'(np[c+2]);
			new_row[c] = (nsum == lgs_pkg::BIRTH_COUNT)
				|| (nsum == lgs_pkg::SURVIVE_COUNT && cp[c+1]);
		end
	end

	always_comb begin
		patched_row        = ram_rdata;
		patched_row[col_q] = val_q;
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = step_q[RW-1:0];
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = row_q;
		if (cmd.clear) begin
			ram_we = 1'b1;
		end
		if (cmd.adv) begin
			ram_re    = (step_q < HEIGHT_C);
			ram_raddr = step_q[RW-1:0];
			ram_we    = (step_q >= TWO_C);
			ram_waddr = wr_step[RW-1:0];
			ram_wdata = new_row;
		end
		if (cmd.rd) begin
			ram_re = 1'b1;
		end
		if (cmd.rmw) begin
			ram_we    = (op_q == lgs_pkg::OP_WRITE) && in_range_q;
			ram_waddr = row_q;
			ram_wdata = patched_row;
		end
	end

	lgs_ram #(
		.WIDTH(GRID_WIDTH),
		.DEPTH(GRID_HEIGHT)
	) u_grid_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign sts.clear_last = (step_q == CLEAR_LAST_C);
	assign sts.adv_last   = (step_q == ADV_LAST_C);
	assign alive          = alive_q;
	assign done_kind      = op_q;

	`LGS_ASSERT_NEVER(a_no_rw_collision, clk, arst_n,
		ram_we && ram_re && ram_waddr == ram_raddr)
	`LGS_ASSERT(a_clear_writes_zero, clk, arst_n,
		cmd.clear |-> (ram_we && ram_wdata == '0))
	`LGS_ASSERT(a_alive_only_read, clk, arst_n,
		alive_q |-> op_q == lgs_pkg::OP_READ)

endmodule

// File: rtl/core/life_generation_step.sv
// Top level of the bounded B3/S23 life grid: controller plus datapath.
// Depends on lgs_pkg, lgs_ctrl, lgs_datapath (and through it lgs_ram).
`timescale 1ns / 1ps

//  channel   | handshake                | payload
//  ----------+--------------------------+--------------------------------
//  request   | start in, busy out       | op, cell_index, cell_value
//  result    | done out (1-cycle strobe)| alive, done_kind
//
//  After reset a clearing pass writes every grid row dead, one row per
//  cycle; busy stays high until the pass ends.
//  Write and read: the strobe follows states DIV1, DIV2, RD and RMW (reciprocal
//  row/column split in two steps, row read, read-modify-write of one row).
//  Advance: the strobe follows the sweep, which moves one row per cycle
//  through the row RAM (one read and one write port).
//  Unused op code: strobe in the cycle after accept, grid untouched.
//  One request in flight; busy covers it until the strobe cycle ends.
//  The receiver cannot stall: each result is shown for exactly one cycle.

module life_generation_step #(
	parameter int GRID_WIDTH  = 64,
	parameter int GRID_HEIGHT = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [lgs_pkg::OP_W-1:0]  op,
	input  logic [lgs_pkg::IDX_W-1:0] cell_index,
	input  logic                      cell_value,
	output logic                      done,
	output logic                      alive,
	output logic [lgs_pkg::OP_W-1:0]  done_kind
);

	// command and status between sequencer and datapath
	lgs_pkg::cmd_t cmd;
	lgs_pkg::sts_t sts;

	// sequencer: reset clear pass, cell access steps, generation sweep
	lgs_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.op    (op),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	// grid stored one row per RAM word; three row registers feed the rule
	lgs_datapath #(
		.GRID_WIDTH (GRID_WIDTH),
		.GRID_HEIGHT(GRID_HEIGHT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.op        (op),
		.cell_index(cell_index),
		.cell_value(cell_value),
		.alive     (alive),
		.done_kind (done_kind)
	);

endmodule
